FILE: src/sprq_pkg.sv
// Shared types, constants and helpers for the stable priority request queue.
// No dependencies; every other file of the block but sprq_ram imports this package.
`default_nettype none

package sprq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W      = 8;
  localparam int WORD_W      = 64;
  localparam int CLIENT_W    = 16;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [PRIO_W-1:0] prio_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  // Everything an entry carries besides its priority.
  typedef struct packed {
    logic [WORD_W-1:0]   range_start;
    logic [WORD_W-1:0]   range_end;
    logic [WORD_W-1:0]   digest_0;
    logic [WORD_W-1:0]   digest_1;
    logic [WORD_W-1:0]   digest_2;
    logic [WORD_W-1:0]   digest_3;
    logic [CLIENT_W-1:0] client;
  } payload_t;

  // Link store read request; claim marks a read that allocates the slot.
  typedef struct packed {
    logic  en;
    logic  claim;
    slot_t addr;
  } link_rd_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
    slot_t data;
  } link_wr_t;

  // Successor of a slot on the free chain as it stands after reset.
  function automatic slot_t slot_succ(slot_t s);
    slot_t r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/sprq_req_if.sv
// Request channel of the stable priority request queue: valid, ready, payload.
// Depends on sprq_pkg.
`default_nettype none

interface sprq_req_if;
  import sprq_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [PRIO_W-1:0]   priority_req;
  logic [WORD_W-1:0]   range_start;
  logic [WORD_W-1:0]   range_end;
  logic [WORD_W-1:0]   digest_word_0;
  logic [WORD_W-1:0]   digest_word_1;
  logic [WORD_W-1:0]   digest_word_2;
  logic [WORD_W-1:0]   digest_word_3;
  logic [CLIENT_W-1:0] client;

  modport source (
    output valid, kind, priority_req, range_start, range_end,
           digest_word_0, digest_word_1, digest_word_2, digest_word_3, client,
    input  ready
  );

  modport sink (
    input  valid, kind, priority_req, range_start, range_end,
           digest_word_0, digest_word_1, digest_word_2, digest_word_3, client,
    output ready
  );

endinterface

`default_nettype wire

FILE: src/sprq_rsp_if.sv
// Result channel of the stable priority request queue: valid, ready, payload.
// Depends on sprq_pkg.
`default_nettype none

interface sprq_rsp_if;
  import sprq_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [PRIO_W-1:0]   out_priority;
  logic [WORD_W-1:0]   out_range_start;
  logic [WORD_W-1:0]   out_range_end;
  logic [WORD_W-1:0]   out_digest_word_0;
  logic [WORD_W-1:0]   out_digest_word_1;
  logic [WORD_W-1:0]   out_digest_word_2;
  logic [WORD_W-1:0]   out_digest_word_3;
  logic [CLIENT_W-1:0] out_client;

  modport source (
    output valid, status, out_priority, out_range_start, out_range_end,
           out_digest_word_0, out_digest_word_1, out_digest_word_2,
           out_digest_word_3, out_client,
    input  ready
  );

  modport sink (
    input  valid, status, out_priority, out_range_start, out_range_end,
           out_digest_word_0, out_digest_word_1, out_digest_word_2,
           out_digest_word_3, out_client,
    output ready
  );

endinterface

`default_nettype wire

FILE: src/sprq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/sprq_link_store.sv
// Link store: slot link RAM plus a fill count that stands in for the reset
// free chain. Depends on sprq_pkg and sprq_ram.
`default_nettype none

module sprq_link_store (
  input  logic               clk,
  input  logic               rst_n,
  input  sprq_pkg::link_rd_t rd,
  input  sprq_pkg::link_wr_t wr,
  output sprq_pkg::slot_t    link_q
);
  import sprq_pkg::*;

  occ_t  fill_r, fill_nxt;
  logic  fresh_r;
  slot_t addr_r;
  slot_t ram_q;
  logic  rd_fresh;

  // A slot at or above the fill count was never allocated: its link is
  // still the one the reset chain gave it.
  assign rd_fresh = (OCC_W'(rd.addr) >= fill_r);

  always_comb begin
    fill_nxt = fill_r;
    if (rd.en && rd.claim && rd_fresh && (fill_r != OCC_W'(QUEUE_DEPTH))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      fresh_r <= rd_fresh;
      addr_r  <= rd.addr;
    end
  end

  sprq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_q)
  );

  assign link_q = fresh_r ? slot_succ(addr_r) : ram_q;

endmodule

`default_nettype wire

FILE: src/stable_priority_request_queue.sv
// Top level of the stable priority request queue.
// Depends on sprq_pkg, sprq_req_if, sprq_rsp_if, sprq_ram, sprq_link_store.
//
// Bounded priority queue of QUEUE_DEPTH search requests, kept as a linked list
// in slot RAMs with unused slots on a free chain. An enqueue beat inserts the
// request behind every stored entry of equal or higher priority, so equal
// priorities leave in arrival order; a full queue drops it and answers
// status FULL. A dequeue beat returns the head entry (status DELIVERED) or
// status EMPTY. Every beat gives exactly one result beat. One item is worked
// at a time: in_ch.ready is high only while the sequencer is idle, but a
// result waiting in the output register does not block the next request.
// A full enqueue or an empty dequeue goes straight to S_RESP; a dequeue or an
// enqueue that needs no list walk passes S_DEQ or S_ALLOC first; an enqueue
// that must walk the list passes S_ALLOC, S_WLINK, S_WALK and, for a splice,
// S_WFIX, and the list walk advances one entry a cycle through the link and
// priority RAM read ports. S_RESP waits for a free output register. No
// clearing pass is needed after reset.
`default_nettype none

module stable_priority_request_queue (
  input  logic            clk,
  input  logic            rst_n,
  sprq_req_if.sink        in_ch,
  sprq_rsp_if.source      out_ch
);
  import sprq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ALLOC = 7'b0000010,
    S_WLINK = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_WFIX  = 7'b0010000,
    S_DEQ   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  slot_t   first_r, first_nxt;
  slot_t   last_r, last_nxt;
  slot_t   free_r, free_nxt;
  occ_t    occ_r, occ_nxt;
  prio_t   req_prio_r, req_prio_nxt;
  slot_t   ns_r, ns_nxt;
  slot_t   cur_r, cur_nxt;
  slot_t   nxt_r, nxt_nxt;
  status_t status_r, status_nxt;

  logic     out_valid_r, out_valid_nxt;
  status_t  out_status_r;
  prio_t    out_prio_r;
  payload_t out_pay_r;
  logic     out_load;

  // RAM controls
  logic     pay_we, pay_re;
  slot_t    pay_waddr, pay_raddr;
  payload_t pay_wdata, pay_rdata;
  logic     prio_we, prio_re;
  slot_t    prio_waddr, prio_raddr;
  prio_t    prio_wdata, prio_rdata;
  link_rd_t link_rd;
  link_wr_t link_wr;
  slot_t    link_q;

  logic in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    free_nxt     = free_r;
    occ_nxt      = occ_r;
    req_prio_nxt = req_prio_r;
    ns_nxt       = ns_r;
    cur_nxt      = cur_r;
    nxt_nxt      = nxt_r;
    status_nxt   = status_r;
    out_load     = 1'b0;

    pay_we     = 1'b0;
    pay_waddr  = free_r;
    pay_wdata  = '{range_start: in_ch.range_start, range_end: in_ch.range_end,
                   digest_0: in_ch.digest_word_0, digest_1: in_ch.digest_word_1,
                   digest_2: in_ch.digest_word_2, digest_3: in_ch.digest_word_3,
                   client: in_ch.client};
    pay_re     = 1'b0;
    pay_raddr  = first_r;
    prio_we    = 1'b0;
    prio_waddr = free_r;
    prio_wdata = in_ch.priority_req;
    prio_re    = 1'b0;
    prio_raddr = first_r;
    link_rd    = '{en: 1'b0, claim: 1'b0, addr: first_r};
    link_wr    = '{en: 1'b0, addr: first_r, data: ns_r};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_t'(in_ch.kind) == KIND_ENQ) begin
            if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
              // drop the request, state untouched
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              // store the request in the free head slot, fetch its link
              pay_we       = 1'b1;
              prio_we      = 1'b1;
              link_rd      = '{en: 1'b1, claim: 1'b1, addr: free_r};
              prio_re      = (occ_r != '0);
              ns_nxt       = free_r;
              req_prio_nxt = in_ch.priority_req;
              state_nxt    = S_ALLOC;
            end
          end else begin
            if (occ_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              pay_re    = 1'b1;
              prio_re   = 1'b1;
              link_rd   = '{en: 1'b1, claim: 1'b0, addr: first_r};
              state_nxt = S_DEQ;
            end
          end
        end
      end

      S_ALLOC: begin
        free_nxt   = link_q;
        occ_nxt    = occ_r + 1'b1;
        status_nxt = ST_ENQUEUED;
        if (occ_r == '0) begin
          first_nxt = ns_r;
          last_nxt  = ns_r;
          state_nxt = S_RESP;
        end else if (prio_rdata < req_prio_r) begin
          // new head
          link_wr   = '{en: 1'b1, addr: ns_r, data: first_r};
          first_nxt = ns_r;
          state_nxt = S_RESP;
        end else if (first_r == last_r) begin
          // single entry: append behind it
          link_wr   = '{en: 1'b1, addr: first_r, data: ns_r};
          last_nxt  = ns_r;
          state_nxt = S_RESP;
        end else begin
          cur_nxt   = first_r;
          link_rd   = '{en: 1'b1, claim: 1'b0, addr: first_r};
          state_nxt = S_WLINK;
        end
      end

      S_WLINK: begin
        // successor of cur known: fetch its priority and its link together
        nxt_nxt    = link_q;
        prio_re    = 1'b1;
        prio_raddr = link_q;
        link_rd    = '{en: 1'b1, claim: 1'b0, addr: link_q};
        state_nxt  = S_WALK;
      end

      S_WALK: begin
        if (prio_rdata >= req_prio_r) begin
          // advance past nxt
          cur_nxt = nxt_r;
          if (nxt_r == last_r) begin
            link_wr   = '{en: 1'b1, addr: nxt_r, data: ns_r};
            last_nxt  = ns_r;
            state_nxt = S_RESP;
          end else begin
            nxt_nxt    = link_q;
            prio_re    = 1'b1;
            prio_raddr = link_q;
            link_rd    = '{en: 1'b1, claim: 1'b0, addr: link_q};
          end
        end else begin
          // splice in between cur and nxt: new slot first
          link_wr   = '{en: 1'b1, addr: ns_r, data: nxt_r};
          state_nxt = S_WFIX;
        end
      end

      S_WFIX: begin
        link_wr   = '{en: 1'b1, addr: cur_r, data: ns_r};
        state_nxt = S_RESP;
      end

      S_DEQ: begin
        // head data is on the read ports; return the slot to the free chain
        link_wr    = '{en: 1'b1, addr: first_r, data: free_r};
        free_nxt   = first_r;
        occ_nxt    = occ_r - 1'b1;
        status_nxt = ST_DELIVERED;
        if (occ_r == OCC_W'(1)) begin
          first_nxt = '0;
          last_nxt  = '0;
        end else begin
          first_nxt = link_q;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      last_r      <= '0;
      free_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      free_r      <= free_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_prio_r <= req_prio_nxt;
    ns_r       <= ns_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    status_r   <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      if (status_r == ST_DELIVERED) begin
        out_prio_r <= prio_rdata;
        out_pay_r  <= pay_rdata;
      end else begin
        out_prio_r <= '0;
        out_pay_r  <= '0;
      end
    end
  end

  sprq_ram #(
    .WIDTH ($bits(payload_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  sprq_ram #(
    .WIDTH (PRIO_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_waddr),
    .wdata (prio_wdata),
    .re    (prio_re),
    .raddr (prio_raddr),
    .rdata (prio_rdata)
  );

  sprq_link_store u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (link_rd),
    .wr     (link_wr),
    .link_q (link_q)
  );

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.out_priority       = out_prio_r;
  assign out_ch.out_range_start    = out_pay_r.range_start;
  assign out_ch.out_range_end      = out_pay_r.range_end;
  assign out_ch.out_digest_word_0  = out_pay_r.digest_0;
  assign out_ch.out_digest_word_1  = out_pay_r.digest_1;
  assign out_ch.out_digest_word_2  = out_pay_r.digest_2;
  assign out_ch.out_digest_word_3  = out_pay_r.digest_3;
  assign out_ch.out_client         = out_pay_r.client;

endmodule

`default_nettype wire

FILE: src/sprq_checker.sv
// Port-level assertions for the stable priority request queue, bound to the
// top level. Depends on sprq_pkg.
`default_nettype none

module sprq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic [sprq_pkg::PRIO_W-1:0]   out_priority,
  input logic [sprq_pkg::CLIENT_W-1:0] out_client
);
  import sprq_pkg::*;

  // beats accepted whose result beat has not gone out yet
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two beats in flight");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_ready)
    else $error("request taken while one is in work and one waits");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat without a pending request");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status != ST_DELIVERED)) |-> (out_priority == '0 && out_client == '0))
    else $error("non-delivery result carries entry data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(out_client)))
    else $error("stalled result beat changed");

endmodule

bind stable_priority_request_queue sprq_checker u_sprq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_priority (out_ch.out_priority),
  .out_client   (out_ch.out_client)
);

`default_nettype wire

FILE: test/sprq_order_checker.sv
`timescale 1ns / 1ps
// Order checker for the stable priority request queue: watches both channels,
// predicts each result beat and compares it field by field.
// Depends on sprq_pkg, sprq_req_if and sprq_rsp_if.
`default_nettype none

module sprq_order_checker (
  input  logic clk,
  input  logic rst_n,
  sprq_req_if  req_mon,
  sprq_rsp_if  rsp_mon,
  output int   mismatches,
  output int   outstanding
);
  import sprq_pkg::*;

  typedef struct packed {
    prio_t    prio;
    payload_t data;
  } entry_t;

  typedef struct packed {
    status_t  status;
    prio_t    prio;
    payload_t data;
  } result_t;

  // Predicted queue contents in service order, head first.
  entry_t  queued[$];
  // Results owed by the block, oldest first.
  result_t awaited[$];

  int err_cnt  = 0;
  int wait_cnt = 0;

  assign mismatches  = err_cnt;
  assign outstanding = wait_cnt;

  // Apply one request to the predicted queue and return the result it owes.
  function automatic result_t serve_request(logic kind, prio_t prio, payload_t data);
    result_t r;
    entry_t  e;
    int      pos;
    r = '0;
    if (kind == KIND_ENQ) begin
      if (queued.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.prio = prio;
        e.data = data;
        // Land behind every entry of equal or higher priority.
        pos = queued.size();
        for (int i = 0; i < queued.size(); i++) begin
          if (pos == queued.size() && queued[i].prio < prio) begin
            pos = i;
          end
        end
        queued.insert(pos, e);
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (queued.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = queued.pop_front();
        r.status = ST_DELIVERED;
        r.prio   = e.prio;
        r.data   = e.data;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t  want;
    payload_t data;
    if (rst_n) begin
      // Result first: a request taken at this edge cannot answer at the same edge.
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got status %h",
                   $time, rsp_mon.status);
          err_cnt++;
        end else begin
          want = awaited.pop_front();
          check_field("status",        WORD_W'(want.status),
                      WORD_W'(rsp_mon.status));
          check_field("priority",      WORD_W'(want.prio),
                      WORD_W'(rsp_mon.out_priority));
          check_field("range_start",   want.data.range_start, rsp_mon.out_range_start);
          check_field("range_end",     want.data.range_end,   rsp_mon.out_range_end);
          check_field("digest_word_0", want.data.digest_0,    rsp_mon.out_digest_word_0);
          check_field("digest_word_1", want.data.digest_1,    rsp_mon.out_digest_word_1);
          check_field("digest_word_2", want.data.digest_2,    rsp_mon.out_digest_word_2);
          check_field("digest_word_3", want.data.digest_3,    rsp_mon.out_digest_word_3);
          check_field("client",        WORD_W'(want.data.client),
                      WORD_W'(rsp_mon.out_client));
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        data.range_start = req_mon.range_start;
        data.range_end   = req_mon.range_end;
        data.digest_0    = req_mon.digest_word_0;
        data.digest_1    = req_mon.digest_word_1;
        data.digest_2    = req_mon.digest_word_2;
        data.digest_3    = req_mon.digest_word_3;
        data.client      = req_mon.client;
        awaited.push_back(serve_request(req_mon.kind, req_mon.priority_req, data));
      end
      wait_cnt = awaited.size();
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_stable_priority_request_queue.sv
`timescale 1ns / 1ps
// Testbench top for the stable priority request queue: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on sprq_pkg, both
// channel interfaces, the block and sprq_order_checker.
`default_nettype none

module tb_stable_priority_request_queue;
  import sprq_pkg::*;

  localparam int ITEMS       = 2000;  // stop offering new beats past this count
  localparam int IDLE_PCT    = 12;    // idle chance per cycle on either side
  localparam int HOLD_AT     = 600;   // beat count that triggers the long stall
  localparam int HOLD_CYCLES = 400;   // length of the long receiver stall
  localparam int QUIET_FROM  = 1200;  // window with no idling on either side
  localparam int QUIET_TO    = 1500;
  localparam int DRAIN_TAIL  = 80;    // above the longest list walk of the block

  typedef struct packed {
    logic     kind;
    prio_t    prio;
    payload_t data;
  } req_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sprq_req_if in_ch ();
  sprq_rsp_if out_ch ();

  int mismatches;
  int outstanding;

  // Stimulus bookkeeping; hold_go and quiet pass to the receiver process.
  int   sent = 0;
  logic hold_go;
  logic quiet;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  stable_priority_request_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sprq_order_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_ch),
    .rsp_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // Receiver: random back-pressure, one long stall once the sender is well
  // under way, and a stretch of steady ready inside the quiet window. Every
  // branch makes exactly one assignment to ready per edge.
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Hard stop in case the block hangs; several times the slowest legal run.
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Mostly dense random words, with the all-zero and all-one patterns mixed in.
  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic payload_t rand_payload();
    payload_t d;
    d.range_start = rand_word();
    d.range_end   = rand_word();
    d.digest_0    = rand_word();
    d.digest_1    = rand_word();
    d.digest_2    = rand_word();
    d.digest_3    = rand_word();
    d.client      = CLIENT_W'($urandom);
    return d;
  endfunction

  // Priority mix per round style: ties, extremes, or the full range.
  function automatic prio_t pick_prio(int mode);
    int pick;
    if (mode == 8) begin
      return prio_t'($urandom_range(3));
    end else if (mode == 9) begin
      return ($urandom_range(1) != 0) ? '1 : '0;
    end else if (mode == 6) begin
      return prio_t'($urandom_range(7));
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end else if (pick < 5) begin
      return prio_t'($urandom_range(3));
    end
    return prio_t'($urandom_range(255));
  endfunction

  // Drive one request beat and hold it until the block takes it. Idle cycles
  // go in front of the beat, so valid drops only between beats.
  task automatic offer(req_beat_t r);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= r.kind;
    in_ch.priority_req  <= r.prio;
    in_ch.range_start   <= r.data.range_start;
    in_ch.range_end     <= r.data.range_end;
    in_ch.digest_word_0 <= r.data.digest_0;
    in_ch.digest_word_1 <= r.data.digest_1;
    in_ch.digest_word_2 <= r.data.digest_2;
    in_ch.digest_word_3 <= r.data.digest_3;
    in_ch.client        <= r.data.client;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    sent++;
    if (sent == HOLD_AT) begin
      hold_go <= 1'b1;
    end
    quiet <= (sent >= QUIET_FROM && sent < QUIET_TO);
  endtask

  task automatic enqueue(prio_t p, payload_t d);
    req_beat_t r;
    r.kind = KIND_ENQ;
    r.prio = p;
    r.data = d;
    offer(r);
  endtask

  // Dequeue beats carry random payload; the block must ignore it.
  task automatic dequeue();
    req_beat_t r;
    r.kind = KIND_DEQ;
    r.prio = prio_t'($urandom);
    r.data = rand_payload();
    offer(r);
  endtask

  initial begin
    int mode;
    int len;
    int enq_pct;

    // Every input known from time zero.
    rst_n               = 1'b0;
    hold_go             = 1'b0;
    quiet               = 1'b0;
    out_ch.ready        = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_ENQ;
    in_ch.priority_req  = '0;
    in_ch.range_start   = '0;
    in_ch.range_end     = '0;
    in_ch.digest_word_0 = '0;
    in_ch.digest_word_1 = '0;
    in_ch.digest_word_2 = '0;
    in_ch.digest_word_3 = '0;
    in_ch.client        = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dequeue on empty, extreme priorities and payloads, a run of
    // equal priorities that must leave in arrival order, head and tail
    // inserts, then drain past empty.
    dequeue();
    enqueue('0, '0);
    enqueue('1, '1);
    repeat (3) enqueue(prio_t'(128), rand_payload());
    enqueue('1, rand_payload());
    enqueue('0, rand_payload());
    enqueue(prio_t'(1), rand_payload());
    enqueue(prio_t'(254), rand_payload());
    repeat (10) dequeue();

    // Random rounds: mixed traffic, fills past full, drains past empty,
    // tie-heavy and extremes-only runs.
    while (sent < ITEMS) begin
      mode = $urandom_range(9);
      case (mode)
        6: begin
          repeat (QUEUE_DEPTH + $urandom_range(1, 6)) enqueue(pick_prio(mode), rand_payload());
        end
        7: begin
          repeat (QUEUE_DEPTH + $urandom_range(1, 6)) dequeue();
        end
        default: begin
          len     = $urandom_range(10, 60);
          enq_pct = $urandom_range(35, 75);
          repeat (len) begin
            if ($urandom_range(99) < enq_pct) begin
              enqueue(pick_prio(mode), rand_payload());
            end else begin
              dequeue();
            end
          end
        end
      endcase
    end

    // Drop valid, wait for every owed result, then give the block time to
    // show any stray beat.
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (outstanding != 0);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/sprq_pkg.sv
src/sprq_req_if.sv
src/sprq_rsp_if.sv
src/sprq_ram.sv
src/sprq_link_store.sv
src/stable_priority_request_queue.sv
src/sprq_checker.sv
test/sprq_order_checker.sv
test/tb_stable_priority_request_queue.sv
